// ----- sv/sos_pkg.sv -----
package sos_pkg;

    // Sizes of the history and of the range values.
    localparam int HISTORY_DEPTH = 3;
    localparam int DISTANCE_BITS = 10;

    // Fixed field widths.
    localparam int ANGLE_BITS     = 8;
    localparam int STEP_BITS      = 6;
    localparam int COUNT_BITS     = 6;
    localparam int WIDTH_BITS     = 19;
    localparam int ANGLE_EXT_BITS = ANGLE_BITS + 2;
    localparam int DIFF_BITS      = ANGLE_BITS + 3;
    localparam int SINE_BITS      = 17;
    localparam int DS_BITS        = 17;

    // History sum and fill count.
    localparam int FILL_BITS = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_BITS  = DISTANCE_BITS + $clog2(HISTORY_DEPTH + 1);

    // Configuration port.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = (DISTANCE_BITS > ANGLE_BITS) ? DISTANCE_BITS : ANGLE_BITS;

    // Queue depths.
    localparam int CMD_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    // Width rounding and moving average weights (Q.8).
    localparam int ROUND_SHIFT = 7;
    localparam int ROUND_HALF  = 64;
    localparam int EMA_NEW     = 179;
    localparam int EMA_OLD     = 77;
    localparam int EMA_SHIFT   = 8;
    localparam int EMA_HALF    = 128;

    // Quarter wave sine, round(sin(d) * 32768) for d = 0..90 degrees.
    localparam logic [15:0] SINE_Q15 [0:90] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
        16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
        16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
        16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
        16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
        16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
        16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
        16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
        16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
        16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
        16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
    };

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_NEAR     = 3'd0,
        CFG_FAR      = 3'd1,
        CFG_MIN_SPAN = 3'd2,
        CFG_STEP     = 3'd3,
        CFG_CENTER   = 3'd4,
        CFG_MAX_REC  = 3'd5
    } t_cfg_reg;

    // Record kinds.
    typedef enum logic {
        KIND_OBSTACLE = 1'b0,
        KIND_DONE     = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        F_IDLE,
        F_AVG,
        F_RUN,
        F_TAIL,
        F_DONE
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SINE,
        B_MULT,
        B_ROUND,
        B_EMA,
        B_PUSH
    } t_back_state;

    typedef struct packed {
        logic [DISTANCE_BITS-1:0] near;
        logic [DISTANCE_BITS-1:0] far;
        logic [ANGLE_BITS-1:0]    min_span;
        logic [STEP_BITS-1:0]     step;
        logic [ANGLE_BITS-1:0]    center;
        logic [COUNT_BITS-1:0]    max_rec;
    } t_cfg;

    // Work handed from the front to the back: a closed run or a done record.
    typedef struct packed {
        t_kind                      kind;
        logic                       emit;
        logic [ANGLE_BITS-1:0]      start;
        logic signed [ANGLE_EXT_BITS-1:0] end_pos;
        logic [ANGLE_BITS-1:0]      span;
        logic [DISTANCE_BITS-1:0]   nearest;
        logic [COUNT_BITS-1:0]      count;
        logic                       is_last;
    } t_cmd;

    typedef struct packed {
        t_kind                    kind;
        logic [ANGLE_BITS-1:0]    start;
        logic [ANGLE_BITS-1:0]    end_pos;
        logic [ANGLE_BITS-1:0]    span;
        logic [DISTANCE_BITS-1:0] nearest;
        logic [WIDTH_BITS-1:0]    width;
        logic [WIDTH_BITS-1:0]    smoothed;
        logic [COUNT_BITS-1:0]    count;
        logic                     is_last;
    } t_rec;

    // Sine in Q15 of a signed angle difference, folded from the quarter wave.
    function automatic logic signed [SINE_BITS-1:0] sine_q15(
        input logic signed [DIFF_BITS-1:0] diff
    );
        logic signed [DIFF_BITS-1:0] wrapped;
        logic [ANGLE_BITS:0]         r;
        logic [6:0]                  idx;
        logic                        neg;
        logic [15:0]                 mag;
        wrapped = (diff < 0) ? diff + $signed(DIFF_BITS'(360)) : diff;
        r = wrapped[ANGLE_BITS:0];
        if (r <= 9'd90) begin
            idx = 7'(r);
            neg = 1'b0;
        end else if (r <= 9'd180) begin
            idx = 7'(9'd180 - r);
            neg = 1'b0;
        end else if (r <= 9'd270) begin
            idx = 7'(r - 9'd180);
            neg = 1'b1;
        end else begin
            idx = 7'(9'd360 - r);
            neg = 1'b1;
        end
        mag = SINE_Q15[idx];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ----- sv/sos_cmd_queue.sv -----
module sos_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sos_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output sos_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import sos_pkg::*;

    localparam int PTR_BITS = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(CMD_Q_DEPTH + 1);

    t_cmd                r_mem [CMD_Q_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_do_push;
    logic                w_do_pop;

    assign o_full    = (r_count == CNT_BITS'(CMD_Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(CMD_Q_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + PTR_BITS'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(CMD_Q_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + PTR_BITS'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- sv/sos_front.sv -----
module sos_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sos_pkg::t_cfg                       i_cfg,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [sos_pkg::ANGLE_BITS-1:0]      i_angle_deg,
    input  logic [sos_pkg::DISTANCE_BITS-1:0]   i_distance_cm,
    input  logic                                i_echo_ok,
    input  logic                                i_first_of_scan,
    input  logic                                i_last_of_scan,
    output logic                                o_cmd_push,
    output sos_pkg::t_cmd                       o_cmd,
    input  logic                                i_cmd_full
);
    import sos_pkg::*;

    localparam int RECIP_SHIFT = SUM_BITS + FILL_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int QPROD_BITS  = SUM_BITS + RECIP_BITS;

    t_front_state r_state;
    t_front_state n_state;

    logic [ANGLE_BITS-1:0]    r_angle;
    logic                     r_echo;
    logic                     r_last;
    logic [DISTANCE_BITS-1:0] r_hist [HISTORY_DEPTH];
    logic [FILL_BITS-1:0]     r_fill;
    logic [DISTANCE_BITS-1:0] r_avg;
    logic                     r_in_run;
    logic [ANGLE_BITS-1:0]    r_run_start;
    logic [DISTANCE_BITS-1:0] r_run_nearest;
    logic [COUNT_BITS-1:0]    r_records;

    logic [RECIP_BITS-1:0]    w_recip [0:HISTORY_DEPTH];
    logic [SUM_BITS-1:0]      w_sum;
    logic [QPROD_BITS-1:0]    w_qprod;
    logic                     w_det;
    logic signed [ANGLE_EXT_BITS-1:0] w_end;
    logic signed [ANGLE_EXT_BITS-1:0] w_span;
    logic                     w_report;
    logic                     w_emit;
    logic                     w_need_close;
    logic                     w_need_push;
    logic                     w_stall;

    // Reciprocals ceil(2^K / f) turn the average into one multiply.
    assign w_recip[0] = '0;
    for (genvar g = 1; g <= HISTORY_DEPTH; g++) begin : g_recip
        localparam int unsigned RECIP = ((1 << RECIP_SHIFT) + g - 1) / g;
        assign w_recip[g] = RECIP_BITS'(RECIP);
    end

    // Sum over the filled history entries.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (FILL_BITS'(i) < r_fill) begin
                w_sum = w_sum + SUM_BITS'(r_hist[i]);
            end
        end
    end

    assign w_qprod = QPROD_BITS'(w_sum) * QPROD_BITS'(w_recip[r_fill]);

    // Window test, run close angles and record decisions.
    always_comb begin
        w_det = r_echo && (r_avg >= i_cfg.near) && (r_avg <= i_cfg.far);
        if (r_state == F_TAIL) begin
            w_end = $signed(ANGLE_EXT_BITS'(r_angle));
        end else begin
            w_end = $signed(ANGLE_EXT_BITS'(r_angle)) - $signed(ANGLE_EXT_BITS'(i_cfg.step));
        end
        w_span   = w_end - $signed(ANGLE_EXT_BITS'(r_run_start));
        w_report = (w_span >= $signed(ANGLE_EXT_BITS'(i_cfg.min_span)));
        w_emit   = (r_records < i_cfg.max_rec);
        case (r_state)
            F_RUN:   w_need_close = r_in_run && !w_det;
            F_TAIL:  w_need_close = r_in_run;
            default: w_need_close = 1'b0;
        endcase
        w_need_push = (w_need_close && w_report) || (r_state == F_DONE);
        w_stall     = w_need_push && i_cmd_full;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    n_state = i_echo_ok ? F_AVG : F_RUN;
                end
            end
            F_AVG: begin
                n_state = F_RUN;
            end
            F_RUN: begin
                if (!w_stall) begin
                    n_state = r_last ? F_TAIL : F_IDLE;
                end
            end
            F_TAIL: begin
                if (!w_stall) begin
                    n_state = F_DONE;
                end
            end
            F_DONE: begin
                if (!w_stall) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Handshake and command outputs.
    always_comb begin
        o_full     = (r_state != F_IDLE);
        o_cmd_push = w_need_push && !i_cmd_full;
        o_cmd.start   = r_run_start;
        o_cmd.end_pos = w_end;
        o_cmd.span    = w_span[ANGLE_BITS-1:0];
        o_cmd.nearest = r_run_nearest;
        if (r_state == F_DONE) begin
            o_cmd.kind    = KIND_DONE;
            o_cmd.emit    = 1'b1;
            o_cmd.count   = r_records;
            o_cmd.is_last = 1'b1;
        end else begin
            o_cmd.kind    = KIND_OBSTACLE;
            o_cmd.emit    = w_emit;
            o_cmd.count   = w_emit ? r_records + COUNT_BITS'(1) : r_records;
            o_cmd.is_last = !r_last;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_fill    <= '0;
            r_in_run  <= 1'b0;
            r_records <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        if (i_first_of_scan) begin
                            r_in_run  <= 1'b0;
                            r_records <= '0;
                        end
                        if (i_echo_ok) begin
                            if (i_first_of_scan) begin
                                r_fill <= FILL_BITS'(1);
                            end else if (r_fill < FILL_BITS'(HISTORY_DEPTH)) begin
                                r_fill <= r_fill + FILL_BITS'(1);
                            end
                        end else if (i_first_of_scan) begin
                            r_fill <= '0;
                        end
                    end
                end
                F_RUN: begin
                    if (w_det && !r_in_run) begin
                        r_in_run <= 1'b1;
                    end else if (w_need_close && !w_stall) begin
                        r_in_run <= 1'b0;
                        if (w_report && w_emit) begin
                            r_records <= r_records + COUNT_BITS'(1);
                        end
                    end
                end
                F_TAIL: begin
                    if (w_need_close && !w_stall) begin
                        r_in_run <= 1'b0;
                        if (w_report && w_emit) begin
                            r_records <= r_records + COUNT_BITS'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Item fields, history and run payload.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_angle <= i_angle_deg;
            r_echo  <= i_echo_ok;
            r_last  <= i_last_of_scan;
            if (i_echo_ok) begin
                r_hist[0] <= i_distance_cm;
                for (int i = 1; i < HISTORY_DEPTH; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end
        end
        if (r_state == F_AVG) begin
            r_avg <= w_qprod[RECIP_SHIFT +: DISTANCE_BITS];
        end
        if (r_state == F_RUN) begin
            if (w_det && !r_in_run) begin
                r_run_start   <= r_angle;
                r_run_nearest <= r_avg;
            end else if (w_det && (r_avg < r_run_nearest)) begin
                r_run_nearest <= r_avg;
            end
        end
    end

endmodule

// ----- sv/sos_back.sv -----
module sos_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [sos_pkg::ANGLE_BITS-1:0] i_center_deg,
    input  sos_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_empty,
    output logic                           o_cmd_pop,
    output sos_pkg::t_rec                  o_rec,
    output logic                           o_empty,
    input  logic                           i_pop
);
    import sos_pkg::*;

    localparam int PROD_BITS = DISTANCE_BITS + DS_BITS;
    localparam int RND_BITS  = PROD_BITS + 1;
    localparam int EMA_BITS  = WIDTH_BITS + 9;
    localparam int PTR_BITS  = (RES_Q_DEPTH > 1) ? $clog2(RES_Q_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(RES_Q_DEPTH + 1);
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = '1;

    t_back_state r_state;
    t_back_state n_state;

    t_cmd                  r_cmd;
    logic [DS_BITS-1:0]    r_ds;
    logic [PROD_BITS-1:0]  r_prod;
    logic [WIDTH_BITS-1:0] r_width;
    logic [WIDTH_BITS-1:0] r_prior;

    t_rec                  r_q [RES_Q_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [CNT_BITS-1:0]   r_count;

    logic signed [SINE_BITS-1:0] w_sin_end;
    logic signed [SINE_BITS-1:0] w_sin_start;
    logic signed [SINE_BITS:0]   w_sdiff;
    logic signed [SINE_BITS:0]   w_abs;
    logic [RND_BITS-1:0]         w_rounded;
    logic [EMA_BITS-1:0]         w_ema;
    logic                        w_res_full;
    logic                        w_res_push;
    logic                        w_res_pop;
    t_rec                        w_rec;

    // Sine difference between the run edges, seen from the center angle.
    always_comb begin
        w_sin_end = sine_q15($signed({r_cmd.end_pos[ANGLE_EXT_BITS-1], r_cmd.end_pos})
                             - $signed(DIFF_BITS'(i_center_deg)));
        w_sin_start = sine_q15($signed(DIFF_BITS'(r_cmd.start))
                               - $signed(DIFF_BITS'(i_center_deg)));
        w_sdiff = $signed({w_sin_end[SINE_BITS-1], w_sin_end})
                  - $signed({w_sin_start[SINE_BITS-1], w_sin_start});
        w_abs = (w_sdiff < 0) ? -w_sdiff : w_sdiff;
    end

    // Rounding of the width product and the moving average.
    always_comb begin
        w_rounded = ({1'b0, r_prod} + RND_BITS'(ROUND_HALF)) >> ROUND_SHIFT;
        w_ema = (EMA_BITS'(EMA_NEW) * EMA_BITS'(r_width)
                 + EMA_BITS'(EMA_OLD) * EMA_BITS'(r_prior)
                 + EMA_BITS'(EMA_HALF)) >> EMA_SHIFT;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = (i_cmd.kind == KIND_DONE) ? B_PUSH : B_SINE;
                end
            end
            B_SINE:  n_state = B_MULT;
            B_MULT:  n_state = B_ROUND;
            B_ROUND: n_state = B_EMA;
            B_EMA:   n_state = r_cmd.emit ? B_PUSH : B_IDLE;
            B_PUSH: begin
                if (!w_res_full) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Command pop, result push and the record itself.
    always_comb begin
        o_cmd_pop  = (r_state == B_IDLE) && !i_cmd_empty;
        w_res_push = (r_state == B_PUSH) && !w_res_full;
        w_rec = '0;
        if (r_cmd.kind == KIND_DONE) begin
            w_rec.kind    = KIND_DONE;
            w_rec.count   = r_cmd.count;
            w_rec.is_last = 1'b1;
        end else begin
            w_rec.kind     = KIND_OBSTACLE;
            w_rec.start    = r_cmd.start;
            w_rec.end_pos  = r_cmd.end_pos[ANGLE_BITS-1:0];
            w_rec.span     = r_cmd.span;
            w_rec.nearest  = r_cmd.nearest;
            w_rec.width    = r_width;
            w_rec.smoothed = r_prior;
            w_rec.count    = r_cmd.count;
            w_rec.is_last  = r_cmd.is_last;
        end
    end

    // Result queue status.
    assign w_res_full = (r_count == CNT_BITS'(RES_Q_DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_res_pop  = i_pop && !o_empty;
    assign o_rec      = r_q[r_rd_ptr];

    // Control state: sequencer, kept average width and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_prior  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_EMA) begin
                r_prior <= (w_ema > EMA_BITS'(WIDTH_MAX)) ? WIDTH_MAX
                                                          : w_ema[WIDTH_BITS-1:0];
            end
            if (w_res_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(RES_Q_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + PTR_BITS'(1);
            end
            if (w_res_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(RES_Q_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + PTR_BITS'(1);
            end
            if (w_res_push && !w_res_pop) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_res_pop && !w_res_push) begin
                r_count <= r_count - CNT_BITS'(1);
            end
        end
    end

    // Datapath registers, one step per state.
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == B_SINE) begin
            r_ds <= w_abs[DS_BITS-1:0];
        end
        if (r_state == B_MULT) begin
            r_prod <= PROD_BITS'(r_cmd.nearest) * PROD_BITS'(r_ds);
        end
        if (r_state == B_ROUND) begin
            r_width <= (w_rounded > RND_BITS'(WIDTH_MAX)) ? WIDTH_MAX
                                                          : w_rounded[WIDTH_BITS-1:0];
        end
        if (w_res_push) begin
            r_q[r_wr_ptr] <= w_rec;
        end
    end

endmodule

// ----- sv/sweep_obstacle_segmenter_unit.sv -----
// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------------
// readings  | push / full         | angle, distance, echo_ok, first/last of scan
// records   | pop / empty         | kind, angles, span, nearest, widths, count, is_last
// config    | i_cfg_we            | i_cfg_addr, i_cfg_wdata
//
// The front takes a reading through accept, average and run update, skipping the
// average without an echo; a reading that ends a scan adds a tail close and a done
// request. The back takes a closed run through pop, sine, multiply, round, average and,
// if emitted, push; a done record through pop and push. Reset is synchronous and clears
// control state and the kept width average. Without pop, the result queue fills, then
// the command queue, and the front holds full high until a request can be queued.
module sweep_obstacle_segmenter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sos_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [sos_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic [sos_pkg::ANGLE_BITS-1:0]      i_angle_deg,
    input  logic [sos_pkg::DISTANCE_BITS-1:0]   i_distance_cm,
    input  logic                                i_echo_ok,
    input  logic                                i_first_of_scan,
    input  logic                                i_last_of_scan,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_kind,
    output logic [sos_pkg::ANGLE_BITS-1:0]      o_start_deg,
    output logic [sos_pkg::ANGLE_BITS-1:0]      o_end_deg,
    output logic [sos_pkg::ANGLE_BITS-1:0]      o_span_deg,
    output logic [sos_pkg::DISTANCE_BITS-1:0]   o_nearest_cm,
    output logic [sos_pkg::WIDTH_BITS-1:0]      o_width_q8,
    output logic [sos_pkg::WIDTH_BITS-1:0]      o_smoothed_width_q8,
    output logic [sos_pkg::COUNT_BITS-1:0]      o_record_count,
    output logic                                o_is_last
);
    import sos_pkg::*;

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    t_rec w_rec;
    logic w_cmd_push;
    logic w_cmd_full;
    logic w_cmd_pop;
    logic w_cmd_empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near     <= DISTANCE_BITS'(2);
            r_cfg.far      <= DISTANCE_BITS'(50);
            r_cfg.min_span <= ANGLE_BITS'(10);
            r_cfg.step     <= STEP_BITS'(4);
            r_cfg.center   <= ANGLE_BITS'(90);
            r_cfg.max_rec  <= COUNT_BITS'(20);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_NEAR:     r_cfg.near     <= i_cfg_wdata[DISTANCE_BITS-1:0];
                CFG_FAR:      r_cfg.far      <= i_cfg_wdata[DISTANCE_BITS-1:0];
                CFG_MIN_SPAN: r_cfg.min_span <= i_cfg_wdata[ANGLE_BITS-1:0];
                CFG_STEP:     r_cfg.step     <= i_cfg_wdata[STEP_BITS-1:0];
                CFG_CENTER:   r_cfg.center   <= i_cfg_wdata[ANGLE_BITS-1:0];
                CFG_MAX_REC:  r_cfg.max_rec  <= i_cfg_wdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Front: averaging, run tracking and record decisions.
    sos_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_push          (push),
        .o_full          (full),
        .i_angle_deg     (i_angle_deg),
        .i_distance_cm   (i_distance_cm),
        .i_echo_ok       (i_echo_ok),
        .i_first_of_scan (i_first_of_scan),
        .i_last_of_scan  (i_last_of_scan),
        .o_cmd_push      (w_cmd_push),
        .o_cmd           (w_front_cmd),
        .i_cmd_full      (w_cmd_full)
    );

    // Queue of requests between the two halves.
    sos_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_cmd_empty)
    );

    // Back: width, moving average and result queue.
    sos_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_center_deg (r_cfg.center),
        .i_cmd        (w_queue_cmd),
        .i_cmd_empty  (w_cmd_empty),
        .o_cmd_pop    (w_cmd_pop),
        .o_rec        (w_rec),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_kind              = w_rec.kind;
    assign o_start_deg         = w_rec.start;
    assign o_end_deg           = w_rec.end_pos;
    assign o_span_deg          = w_rec.span;
    assign o_nearest_cm        = w_rec.nearest;
    assign o_width_q8          = w_rec.width;
    assign o_smoothed_width_q8 = w_rec.smoothed;
    assign o_record_count      = w_rec.count;
    assign o_is_last           = w_rec.is_last;

endmodule
